/* src/aphc_pkg.sv */
package aphc_pkg;

    // Field and register widths.
    localparam int VALUE_W = 48;
    localparam int RATE_W  = 16;
    localparam int DUR_W   = 31;
    localparam int POS_W   = 32;
    localparam int PROD_W  = VALUE_W + RATE_W;
    // Target before normalization: position plus the scaled product.
    localparam int TGT_W   = PROD_W - 8 + 1;
    localparam int PER_W   = POS_W + 1;
    localparam int CNT_W   = $clog2(TGT_W);

    // Configuration register indexes.
    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;
    localparam logic [1:0] REG_PAUSED   = 2'd3;

    // Play modes; the unused code behaves as once mode.
    localparam logic [1:0] MODE_ONCE     = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // Item actions.
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_SEEK    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_SUM,
        S_PREP,
        S_DIV,
        S_PLACE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mult;
        logic sum;
        logic prep;
        logic div_step;
        logic place;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic skip_div;
    } stat_t;

endpackage

/* src/aphc_ctrl.sv */
module aphc_ctrl
    import aphc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_ready,
    output logic  out_valid,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               room;

    assign room = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:  state_next = S_SUM;
            S_SUM:   state_next = stat.skip_div ? S_PLACE : S_PREP;
            S_PREP:  state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(TGT_W - 1))
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_OUT;
            S_OUT:
            begin
                if (room)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_MULT:  cmd.mult     = 1'b1;
            S_SUM:   cmd.sum      = 1'b1;
            S_PREP:  cmd.prep     = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_PLACE: cmd.place    = 1'b1;
            S_OUT:   cmd.load_out = room;
            default: cmd          = '0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.prep)
        begin
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/aphc_dp.sv */
module aphc_dp
    import aphc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic        [DUR_W-1:0]   duration,
    input  logic        [1:0]         mode,
    input  logic signed [RATE_W-1:0]  rate,
    input  logic                      paused,
    output logic        [POS_W-1:0]   play_time,
    output logic                      done_res,
    output logic                      bad_input
);

    logic                      act_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [TGT_W-1:0]   tgt_reg;
    logic                      hold_reg;
    logic                      bad_reg;
    logic        [TGT_W-1:0]   mag_reg;
    logic        [POS_W-1:0]   rem_reg;
    logic        [POS_W-1:0]   pos_reg;
    logic        [POS_W-1:0]   play_time_reg;
    logic                      done_reg;
    logic                      bad_out_reg;

    logic                      is_once;
    logic        [POS_W-1:0]   d_eff;
    logic        [PER_W-1:0]   period;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [TGT_W-1:0]   tgt_c;
    logic                      bad_c;
    logic                      hold_c;
    logic        [PER_W-1:0]   trial;
    logic        [POS_W-1:0]   rem_c;
    logic        [POS_W-1:0]   place_c;
    logic signed [PER_W:0]     mirror;
    logic        [POS_W-1:0]   shown_c;
    logic                      done_c;

    assign is_once = (mode != MODE_LOOP) && (mode != MODE_PINGPONG);
    // A zero duration is treated as the shortest clip.
    assign d_eff   = (duration == '0) ? POS_W'(1) : {1'b0, duration};
    assign period  = (mode == MODE_LOOP) ? {1'b0, d_eff} : {d_eff, 1'b0};

    assign prod_c = PROD_W'(val_reg) * PROD_W'(rate);

    // Floor division of the product by 256 is an arithmetic shift.
    always_comb
    begin
        if (act_reg == ACT_SEEK)
        begin
            tgt_c = TGT_W'(val_reg);
        end
        else
        begin
            tgt_c = {prod_reg[PROD_W-1], prod_reg[PROD_W-1:8]}
                    + $signed({{(TGT_W-POS_W){1'b0}}, pos_reg});
        end
    end

    assign bad_c  = (act_reg == ACT_ADVANCE) && val_reg[VALUE_W-1];
    assign hold_c = (act_reg == ACT_ADVANCE) && (val_reg[VALUE_W-1] || paused);
    assign stat.skip_div = hold_c || is_once;

    // One restoring step on the remainder.
    assign trial = {rem_reg, mag_reg[TGT_W-1]};
    assign rem_c = (trial >= period) ? POS_W'(trial - period) : trial[POS_W-1:0];

    always_comb
    begin
        if (is_once)
        begin
            if (tgt_reg[TGT_W-1])
            begin
                place_c = '0;
            end
            else if (tgt_reg > $signed({{(TGT_W-POS_W){1'b0}}, d_eff}))
            begin
                place_c = d_eff;
            end
            else
            begin
                place_c = tgt_reg[POS_W-1:0];
            end
        end
        else if (tgt_reg[TGT_W-1] && (rem_reg != '0))
        begin
            place_c = POS_W'(period - {1'b0, rem_reg});
        end
        else
        begin
            place_c = rem_reg;
        end
    end

    assign mirror = $signed({1'b0, d_eff, 1'b0}) - $signed({2'b00, pos_reg});

    always_comb
    begin
        shown_c = pos_reg;
        if ((mode == MODE_PINGPONG) && (pos_reg > d_eff))
        begin
            shown_c = mirror[PER_W] ? '0 : mirror[POS_W-1:0];
        end
    end

    always_comb
    begin
        done_c = 1'b0;
        if (is_once)
        begin
            done_c = rate[RATE_W-1] ? (pos_reg == '0) : (pos_reg >= d_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= action;
            val_reg <= value;
        end
        if (cmd.mult)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.sum)
        begin
            tgt_reg  <= tgt_c;
            hold_reg <= hold_c;
            bad_reg  <= bad_c;
        end
        if (cmd.prep)
        begin
            mag_reg <= tgt_reg[TGT_W-1] ? TGT_W'(-tgt_reg) : tgt_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= {mag_reg[TGT_W-2:0], 1'b0};
            rem_reg <= rem_c;
        end
        if (cmd.load_out)
        begin
            play_time_reg <= shown_c;
            done_reg      <= done_c;
            bad_out_reg   <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.place && !hold_reg)
        begin
            pos_reg <= place_c;
        end
    end

    assign play_time = play_time_reg;
    assign done_res  = done_reg;
    assign bad_input = bad_out_reg;

endmodule

/* src/animation_playhead_clock.sv */
// Animation playhead clock.
// Items enter on the in_valid/in_ready channel: action selects advance (0) or
// seek (1), and value is a signed Q32.16 delta or seek target. Each item gives
// exactly one result item on out_valid/out_ready: the displayed time, the
// finished flag of once mode and the bad-delta flag.
// The block works on one item at a time. In once mode, and for a paused or
// rejected advance, the item passes the multiply, sum, place and output
// states; in loop and ping-pong mode it also passes the prepare and divide
// states, where a restoring divider reduces the 57-bit target modulo the
// period one bit per cycle. in_ready is high again in the cycle after the
// result is loaded, so a new item can be accepted even while the previous
// result still waits at the output.
// If the receiver stalls, the result register holds its item and the block
// waits with the next result until the register is free.
// Reset clears the position to zero and loads the register defaults: duration
// one second, once mode, normal rate, not paused. The APB port writes the
// registers at any time but only while no item is in flight by convention.
module animation_playhead_clock
    import aphc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic        [POS_W-1:0]   play_time,
    output logic                      done_res,
    output logic                      bad_input,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic        [3:0]         paddr,
    input  logic        [31:0]        pwdata,
    output logic        [31:0]        prdata,
    output logic                      pready
);

    logic        [DUR_W-1:0]  duration_reg, duration_next;
    logic        [1:0]        mode_reg, mode_next;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic                     paused_reg, paused_next;
    logic                     wr_en;
    cmd_t                     cmd;
    stat_t                    stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; the index is the word address.
    always_comb
    begin
        duration_next = duration_reg;
        mode_next     = mode_reg;
        rate_next     = rate_reg;
        paused_next   = paused_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_DURATION: duration_next = pwdata[DUR_W-1:0];
                REG_MODE:     mode_next     = pwdata[1:0];
                REG_RATE:     rate_next     = pwdata[RATE_W-1:0];
                REG_PAUSED:   paused_next   = pwdata[0];
                default:      duration_next = duration_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DURATION: prdata = {1'b0, duration_reg};
            REG_MODE:     prdata = {30'b0, mode_reg};
            REG_RATE:     prdata = {16'b0, rate_reg};
            REG_PAUSED:   prdata = {31'b0, paused_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= DUR_W'(65536);
            mode_reg     <= MODE_ONCE;
            rate_reg     <= RATE_W'(256);
            paused_reg   <= 1'b0;
        end
        else
        begin
            duration_reg <= duration_next;
            mode_reg     <= mode_next;
            rate_reg     <= rate_next;
            paused_reg   <= paused_next;
        end
    end

    // The controller sequences each item; the datapath holds the position,
    // the multiplier, the divider and the result register.
    aphc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    aphc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .value     (value),
        .duration  (duration_reg),
        .mode      (mode_reg),
        .rate      (rate_reg),
        .paused    (paused_reg),
        .play_time (play_time),
        .done_res  (done_res),
        .bad_input (bad_input)
    );

endmodule
